@@ design/gpd_pkg.sv @@
// ----------------------------------------------------------------------------
// gpd_pkg: shared types and constants of the GF(2) polynomial divider
// Holds the coefficient width, the pipeline stage record and the helpers
// that move words between the fixed field width and the coefficient width.
// ----------------------------------------------------------------------------
package gpd_pkg;

  localparam int unsigned PolyW         = 32;
  localparam int unsigned FieldW        = 32;
  localparam int unsigned WorkW         = 2 * PolyW - 1;
  localparam int unsigned ShiftW        = $clog2(PolyW);
  localparam int unsigned StepsPerStage = 4;
  localparam int unsigned NumDivStages  = (PolyW + StepsPerStage - 1) / StepsPerStage;

  localparam logic [FieldW-1:0] GenReset = FieldW'(11);

  typedef logic [FieldW-1:0] field_t;
  typedef logic [PolyW-1:0]  poly_t;
  typedef logic [WorkW-1:0]  work_t;
  typedef logic [ShiftW-1:0] shift_t;

  // The working value holds the dividend scaled up so that the generator's
  // leading coefficient sits at the top of its own word.
  typedef struct packed {
    work_t  work;
    poly_t  quot;
    poly_t  gen_norm;
    shift_t shift;
    logic   gen_zero;
  } gpd_stage_t;

  function automatic poly_t to_poly(input field_t f);
    poly_t r;
    r = '0;
    for (int i = 0; i < int'(PolyW); i++) begin
      if (i < int'(FieldW)) begin
        r[i] = f[i];
      end
    end
    return r;
  endfunction

  function automatic field_t to_field(input poly_t p);
    field_t r;
    r = '0;
    for (int i = 0; i < int'(FieldW); i++) begin
      if (i < int'(PolyW)) begin
        r[i] = p[i];
      end
    end
    return r;
  endfunction

endpackage

@@ design/gpd_in_if.sv @@
// ----------------------------------------------------------------------------
// gpd_in_if: dividend request channel
// Valid/ready channel that carries one dividend polynomial per request.
// ----------------------------------------------------------------------------
interface gpd_in_if;
  import gpd_pkg::*;

  logic   valid;
  logic   ready;
  field_t dividend;

  modport source (output valid, output dividend, input ready);
  modport sink   (input valid, input dividend, output ready);
endinterface

@@ design/gpd_out_if.sv @@
// ----------------------------------------------------------------------------
// gpd_out_if: division result channel
// Valid/ready channel that carries quotient, remainder and the two flags.
// ----------------------------------------------------------------------------
interface gpd_out_if;
  import gpd_pkg::*;

  logic   valid;
  logic   ready;
  field_t quotient;
  field_t remainder;
  logic   remainder_nonzero;
  logic   generator_zero;

  modport source (output valid, output quotient, output remainder,
                  output remainder_nonzero, output generator_zero, input ready);
  modport sink   (input valid, input quotient, input remainder,
                  input remainder_nonzero, input generator_zero, output ready);
endinterface

@@ design/gpd_norm.sv @@
// ----------------------------------------------------------------------------
// gpd_norm: normalization stage
// Finds the generator's degree and shifts generator and dividend left so
// that the generator's leading coefficient lands on the top bit.
// ----------------------------------------------------------------------------
module gpd_norm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gpd_pkg::poly_t     dividend_i,
  input  gpd_pkg::poly_t     generator_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gpd_pkg::gpd_stage_t stage_o
);
  import gpd_pkg::*;

  logic       valid_q;
  gpd_stage_t stage_d, stage_q;
  shift_t     deg;

  always_comb begin
    deg = '0;
    for (int i = 0; i < int'(PolyW); i++) begin
      if (generator_i[i]) begin
        deg = ShiftW'(i);
      end
    end
    stage_d.gen_zero = (generator_i == '0);
    stage_d.shift    = stage_d.gen_zero ? '0 : (ShiftW'(PolyW - 1) - deg);
    stage_d.gen_norm = generator_i << stage_d.shift;
    stage_d.work     = WorkW'(dividend_i) << stage_d.shift;
    stage_d.quot     = '0;
  end

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign stage_o = stage_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      stage_q <= stage_d;
    end
  end

endmodule

@@ design/gpd_div_pipe.sv @@
// ----------------------------------------------------------------------------
// gpd_div_pipe: long-division pipeline
// Each stage retires a fixed group of quotient bits, top degree first, by
// XORing the normalized generator into the working value.
// ----------------------------------------------------------------------------
module gpd_div_pipe (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gpd_pkg::gpd_stage_t stage_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gpd_pkg::gpd_stage_t stage_o
);
  import gpd_pkg::*;

  logic       valid_q  [NumDivStages];
  gpd_stage_t stage_q  [NumDivStages];
  logic       in_valid [NumDivStages];
  gpd_stage_t in_stage [NumDivStages];
  gpd_stage_t stage_d  [NumDivStages];
  logic       dn_ready [NumDivStages];
  logic       up_ready [NumDivStages];

  for (genvar k = 0; k < int'(NumDivStages); k++) begin : g_stage
    if (k == 0) begin : g_first
      assign in_valid[k] = valid_i;
      assign in_stage[k] = stage_i;
    end else begin : g_mid
      assign in_valid[k] = valid_q[k-1];
      assign in_stage[k] = stage_q[k-1];
    end

    if (k == int'(NumDivStages) - 1) begin : g_last
      assign dn_ready[k] = ready_i;
    end else begin : g_inner
      assign dn_ready[k] = up_ready[k+1];
    end

    assign up_ready[k] = !valid_q[k] || dn_ready[k];

    // Quotient bit q is decided by working bit q + PolyW - 1.
    always_comb begin
      int q;
      stage_d[k] = in_stage[k];
      for (int j = 0; j < int'(StepsPerStage); j++) begin
        q = int'(PolyW) - 1 - k * int'(StepsPerStage) - j;
        if (q >= 0) begin
          if (!stage_d[k].gen_zero && stage_d[k].work[q + int'(PolyW) - 1]) begin
            stage_d[k].work = stage_d[k].work ^ (WorkW'(stage_d[k].gen_norm) << q);
            stage_d[k].quot[q] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (up_ready[k]) begin
        valid_q[k] <= in_valid[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (up_ready[k] && in_valid[k]) begin
        stage_q[k] <= stage_d[k];
      end
    end
  end

  assign ready_o = up_ready[0];
  assign valid_o = valid_q[NumDivStages-1];
  assign stage_o = stage_q[NumDivStages-1];

endmodule

@@ design/gpd_denorm.sv @@
// ----------------------------------------------------------------------------
// gpd_denorm: result stage
// Shifts the remainder back down, forms the flags and holds the result
// register that faces the output channel.
// ----------------------------------------------------------------------------
module gpd_denorm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  gpd_pkg::gpd_stage_t stage_i,
  output logic               valid_o,
  input  logic               ready_i,
  output gpd_pkg::field_t    quotient_o,
  output gpd_pkg::field_t    remainder_o,
  output logic               remainder_nonzero_o,
  output logic               generator_zero_o
);
  import gpd_pkg::*;

  logic   valid_q;
  work_t  rem_full;
  poly_t  rem_d;
  field_t quotient_q, remainder_q;
  logic   rem_nz_q, gen_zero_q;

  always_comb begin
    rem_full = stage_i.work >> stage_i.shift;
    rem_d    = rem_full[PolyW-1:0];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      quotient_q  <= to_field(stage_i.quot);
      remainder_q <= to_field(rem_d);
      rem_nz_q    <= (rem_d != '0);
      gen_zero_q  <= stage_i.gen_zero;
    end
  end

  assign valid_o             = valid_q;
  assign quotient_o          = quotient_q;
  assign remainder_o         = remainder_q;
  assign remainder_nonzero_o = rem_nz_q;
  assign generator_zero_o    = gen_zero_q;

endmodule

@@ design/gf2_polynomial_divider.sv @@
// ----------------------------------------------------------------------------
// gf2_polynomial_divider: GF(2) polynomial long division
// Divides each dividend by the configured generator polynomial and returns
// quotient, remainder, a nonzero-remainder flag and a zero-generator flag.
//
// Usage:
// The dividend channel takes one request per cycle under valid/ready; the
// result channel returns one result per request, in order.
// The generator register resets to x^3 + x + 1. The user must write it through
// cfg_we_i/cfg_wdata_i only while the block is idle; the block itself does not
// enforce this. A request passes through one normalization stage, eight
// division stages of four quotient bits each, and one output stage.
// Throughput is one request per cycle while the result channel does not stall.
// Reset empties all stages. When the receiver stalls, the pipeline fills
// and holds; dividend ready drops only once every stage is occupied.
// A zero generator returns the dividend as remainder with zero quotient.
// ----------------------------------------------------------------------------
module gf2_polynomial_divider (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  gpd_pkg::field_t  cfg_wdata_i,
  gpd_in_if.sink           dividend_if,
  gpd_out_if.source        result_if
);
  import gpd_pkg::*;

  field_t     gen_q;
  logic       norm_valid, div_valid, div_ready, den_ready;
  gpd_stage_t norm_stage, div_stage;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q <= GenReset;
    end else if (cfg_we_i) begin
      gen_q <= cfg_wdata_i;
    end
  end

  gpd_norm u_norm (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (dividend_if.valid),
    .ready_o     (dividend_if.ready),
    .dividend_i  (to_poly(dividend_if.dividend)),
    .generator_i (to_poly(gen_q)),
    .valid_o     (norm_valid),
    .ready_i     (div_ready),
    .stage_o     (norm_stage)
  );

  gpd_div_pipe u_div_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (norm_valid),
    .ready_o (div_ready),
    .stage_i (norm_stage),
    .valid_o (div_valid),
    .ready_i (den_ready),
    .stage_o (div_stage)
  );

  gpd_denorm u_denorm (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .valid_i             (div_valid),
    .ready_o             (den_ready),
    .stage_i             (div_stage),
    .valid_o             (result_if.valid),
    .ready_i             (result_if.ready),
    .quotient_o          (result_if.quotient),
    .remainder_o         (result_if.remainder),
    .remainder_nonzero_o (result_if.remainder_nonzero),
    .generator_zero_o    (result_if.generator_zero)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench of the GF(2) polynomial divider
// Sends dividend requests through the valid/ready channel, steps through a
// series of generator settings, and compares every result field against a
// long-division predictor kept in a small scoreboard. Both channels idle at
// random, with some settings run back to back with no idling at all.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gpd_pkg::*;

  localparam int unsigned RandomPerSetting = 95;
  localparam int unsigned DrainCycles      = 12;

  typedef struct packed {
    field_t quotient;
    field_t remainder;
    logic   remainder_nonzero;
    logic   generator_zero;
  } division_t;

  // Index of the highest set coefficient; zero for a zero polynomial.
  function automatic int unsigned poly_degree(input poly_t p);
    int unsigned d;
    d = 0;
    for (int i = 0; i < int'(PolyW); i++) begin
      if (p[i]) begin
        d = i;
      end
    end
    return d;
  endfunction

  class div_scoreboard;
    field_t      generator;
    division_t   expected_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned zero_remainders;
    int unsigned zero_generators;

    function new();
      generator       = GenReset;
      mismatches      = 0;
      checked         = 0;
      zero_remainders = 0;
      zero_generators = 0;
    endfunction

    function division_t divide(input field_t dividend);
      poly_t       work;
      poly_t       gen;
      poly_t       quot;
      int unsigned dg;
      division_t   r;
      work = poly_t'(dividend);
      gen  = poly_t'(generator);
      quot = '0;
      if (gen != '0) begin
        dg = poly_degree(gen);
        for (int d = int'(PolyW) - 1; d >= int'(dg); d--) begin
          if (work[d]) begin
            work ^= gen << (d - dg);
            quot[d - dg] = 1'b1;
          end
        end
      end
      r.quotient          = field_t'(quot);
      r.remainder         = field_t'(work);
      r.remainder_nonzero = (work != '0);
      r.generator_zero    = (gen == '0);
      return r;
    endfunction

    function void note_request(input field_t dividend);
      expected_q = {expected_q, divide(dividend)};
    endfunction

    task report(input string what, input field_t got, input field_t want);
      mismatches++;
      if (mismatches <= 40) begin
        $display("ERROR at %0t ns: %s got %h, expected %h", $time, what, got, want);
      end
    endtask

    task check_result(input division_t got);
      division_t want;
      if (expected_q.size() == 0) begin
        report("result with no request pending, quotient", got.quotient, '0);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (!want.remainder_nonzero) zero_remainders++;
      if (want.generator_zero) zero_generators++;
      if (got.quotient !== want.quotient) begin
        report("quotient", got.quotient, want.quotient);
      end
      if (got.remainder !== want.remainder) begin
        report("remainder", got.remainder, want.remainder);
      end
      if (got.remainder_nonzero !== want.remainder_nonzero) begin
        report("remainder_nonzero", field_t'(got.remainder_nonzero),
               field_t'(want.remainder_nonzero));
      end
      if (got.generator_zero !== want.generator_zero) begin
        report("generator_zero", field_t'(got.generator_zero),
               field_t'(want.generator_zero));
      end
    endtask
  endclass

  logic   clk_i     = 1'b0;
  logic   rst_ni    = 1'b0;
  logic   cfg_we    = 1'b0;
  field_t cfg_wdata = '0;

  int unsigned in_gap_pct    = 0;
  int unsigned out_stall_pct = 0;
  int unsigned settings_used = 0;

  div_scoreboard board = new();

  gpd_in_if  dividend_ch ();
  gpd_out_if result_ch ();

  gf2_polynomial_divider u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .dividend_if (dividend_ch),
    .result_if   (result_ch)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap(input int unsigned pct);
    if ($urandom_range(99) < pct) begin
      return ($urandom_range(9) == 0) ? $urandom_range(40, 10) : $urandom_range(3, 1);
    end
    return 0;
  endfunction

  function automatic field_t random_dividend(input field_t gen);
    int unsigned kind;
    int unsigned dg;
    int unsigned width;
    poly_t       q;
    poly_t       prod;
    field_t      r;
    kind = $urandom_range(99);
    dg   = poly_degree(poly_t'(gen));
    if (kind < 35) begin
      r = $urandom;
    end else if (kind < 55) begin
      width = $urandom_range(FieldW, 1);
      r = field_t'($urandom) & ((field_t'(1) << width) - field_t'(1));
    end else if (kind < 85 && gen != '0) begin
      // An exact multiple of the generator, sometimes with a small remainder
      // folded in below the generator's degree.
      q    = poly_t'($urandom) & ((poly_t'(1) << (PolyW - dg)) - poly_t'(1));
      prod = '0;
      for (int i = 0; i < int'(PolyW); i++) begin
        if (q[i]) begin
          prod ^= poly_t'(gen) << i;
        end
      end
      r = field_t'(prod);
      if (kind >= 72) begin
        r ^= field_t'($urandom) & ((field_t'(1) << dg) - field_t'(1));
      end
    end else if (kind < 93) begin
      case ($urandom_range(3))
        0:       r = '0;
        1:       r = '1;
        2:       r = gen;
        default: r = field_t'(1);
      endcase
    end else begin
      r = field_t'(1) << $urandom_range(FieldW - 1);
    end
    return r;
  endfunction

  task automatic send_dividend(input field_t value);
    int unsigned gap;
    gap = pick_gap(in_gap_pct);
    if (gap != 0) begin
      dividend_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    dividend_ch.valid    <= 1'b1;
    dividend_ch.dividend <= value;
    do @(posedge clk_i); while (!dividend_ch.ready);
    board.note_request(value);
  endtask

  // The register may only change with nothing in flight.
  task automatic set_generator(input field_t value);
    dividend_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we          <= 1'b0;
    board.generator = value;
    settings_used++;
  endtask

  // Result side: check at each accepted result, then decide the next ready.
  initial begin
    int unsigned stall_left;
    division_t   got;
    stall_left      = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && result_ch.valid && result_ch.ready) begin
        got.quotient          = result_ch.quotient;
        got.remainder         = result_ch.remainder;
        got.remainder_nonzero = result_ch.remainder_nonzero;
        got.generator_zero    = result_ch.generator_zero;
        board.check_result(got);
      end
      if (stall_left == 0) begin
        stall_left = pick_gap(out_stall_pct);
      end else begin
        stall_left--;
      end
      result_ch.ready <= (stall_left == 0);
    end
  end

  initial begin
    field_t directed [12];
    field_t settings [12];
    directed = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0007,
      32'h0000_0008, 32'h0000_000B, 32'h0000_0016, 32'h8000_0000,
      32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0005, 32'h7FFF_FFFF
    };
    // Zero, constant, all ones and lone top bit are the extremes; the rest
    // are common code generators and random choices.
    settings = '{
      32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
      32'h8000_0001, 32'h04C1_1DB7, 32'h0000_0003, 32'h0000_0002,
      32'h0000_8005, 32'h0000_0000, 32'h0000_0000, 32'h0000_000B
    };
    dividend_ch.valid    <= 1'b0;
    dividend_ch.dividend <= '0;
    settings[9]  = $urandom;
    settings[10] = $urandom_range(65535, 1);
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // First phase runs on the reset generator, x^3 + x + 1.
    foreach (directed[i]) send_dividend(directed[i]);
    for (int n = 0; n < int'(RandomPerSetting); n++) begin
      send_dividend(random_dividend(board.generator));
    end

    foreach (settings[k]) begin
      if (k % 3 == 1) begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end else begin
        in_gap_pct    = $urandom_range(60);
        out_stall_pct = $urandom_range(60);
      end
      set_generator(settings[k]);
      for (int n = 0; n < int'(RandomPerSetting); n++) begin
        send_dividend(random_dividend(board.generator));
      end
    end

    dividend_ch.valid <= 1'b0;
    while (board.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Checked %0d results under the reset generator and %0d written settings.",
             board.checked, settings_used);
    $display("Of those, %0d had a zero remainder and %0d a zero generator; %0d mismatches.",
             board.zero_remainders, board.zero_generators, board.mismatches);
    if (board.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout: %0d requests still without a result.", board.expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

@@ files.f @@
design/gpd_pkg.sv
design/gpd_in_if.sv
design/gpd_out_if.sv
design/gpd_norm.sv
design/gpd_div_pipe.sv
design/gpd_denorm.sv
design/gf2_polynomial_divider.sv
sim/tb_top.sv
